[rtl/sfc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the streaming FIR convolver.
package sfc_pkg;

    localparam int MAX_TAPS = 64;
    localparam int TAP_AW   = $clog2(MAX_TAPS);
    localparam int LEN_W    = 7;
    localparam int SMP_W    = 24;
    localparam int PROD_W   = 2 * SMP_W;
    localparam int ACC_W    = 56;

    localparam logic [1:0] REQ_TAP    = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TAPS);

    typedef struct packed {
        logic [1:0]              req_type;
        logic [TAP_AW-1:0]       tap_index;
        logic signed [SMP_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] out_value;
        logic                    last_of_tail;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

[rtl/sfc_mac.sv]
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: registered product, then a 56-bit accumulator.
module sfc_mac
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  sfc_pkg::mac_ctl_t                ctl,
    input  logic signed [sfc_pkg::SMP_W-1:0] op_a,
    input  logic signed [sfc_pkg::SMP_W-1:0] op_b,
    output logic signed [sfc_pkg::ACC_W-1:0] acc,
    output logic                             done
);
    import sfc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    mac_ctl_t                 ctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;

    assign prod_next = op_a * op_b;

    always_comb
    begin
        if (ctl_reg.first)
        begin
            acc_next = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        else
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.valid && ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

[rtl/streaming_fir_convolver.sv]
`timescale 1ns / 1ps
// Top level of the streaming FIR convolver with its tap and history memories.
//
// Requests arrive on req with req_valid and req_stall; results leave on res with
// res_valid and res_stall. A beat is taken when valid is high and stall is low.
// A tap load writes one coefficient and yields nothing. A sample beat yields one
// exact convolution output, for which one multiply-accumulate unit visits each of
// the L taps in turn, where L is the kernel length in use. The next request can be
// taken in the same cycle that the result appears. A finish beat yields L - 1 tail
// outputs, the last one flagged, and then forgets the sample history. The block takes
// one request at a time and holds req_stall high while it works. The user must write
// the length register through cfg_we and cfg_data only while the block is idle;
// the block itself does not enforce this. Reset empties the kernel and the history,
// so both read as zero, and sets the length to 64. When the receiver stalls, the
// finished result waits in the output register and the sequencer waits before it
// loads the next one.
module streaming_fir_convolver
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  sfc_pkg::in_item_t                req,
    output logic                             res_valid,
    input  logic                             res_stall,
    output sfc_pkg::out_item_t               res,
    input  logic                             cfg_we,
    input  logic [sfc_pkg::LEN_W-1:0]        cfg_data
);
    import sfc_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_EMIT} state_t;

    state_t              state_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [TAP_AW-1:0]   k_reg;
    logic [TAP_AW-1:0]   t_reg;
    logic                fin_reg;
    logic [TAP_AW-1:0]   wp_reg;
    logic [TAP_AW-1:0]   wp_next;
    out_item_t           res_reg;
    logic                res_valid_reg;

    logic signed [SMP_W-1:0] tap_mem  [MAX_TAPS];
    logic signed [SMP_W-1:0] hist_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]     tap_vld_reg;
    logic [MAX_TAPS-1:0]     hist_vld_reg;

    logic signed [SMP_W-1:0] tap_q_reg;
    logic signed [SMP_W-1:0] hist_q_reg;
    logic                    tap_ok_reg;
    logic                    hist_ok_reg;
    mac_ctl_t                rd_ctl_reg;

    logic [LEN_W-1:0]        len_use;
    logic [TAP_AW-1:0]       last_k;
    logic [TAP_AW-1:0]       hist_addr;
    logic                    accept;
    logic                    out_free;
    mac_ctl_t                issue_ctl;
    logic signed [SMP_W-1:0] tap_op;
    logic signed [SMP_W-1:0] hist_op;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_done;

    always_comb
    begin
        priority if (len_reg < LEN_MIN)
        begin
            len_use = LEN_MIN;
        end
        else if (len_reg > LEN_MAX)
        begin
            len_use = LEN_MAX;
        end
        else
        begin
            len_use = len_reg;
        end
    end

    assign last_k    = TAP_AW'(len_use - LEN_W'(1));
    assign hist_addr = wp_reg - k_reg + t_reg;
    assign wp_next   = wp_reg + TAP_AW'(1);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !res_valid_reg || !res_stall;

    assign issue_ctl.valid = (state_reg == ST_RUN);
    assign issue_ctl.first = (k_reg == t_reg);
    assign issue_ctl.last  = (k_reg == last_k);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_MAX;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            t_reg         <= '0;
            fin_reg       <= 1'b0;
            wp_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && !res_stall && (state_reg != ST_EMIT))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.req_type == REQ_SAMPLE)
                        begin
                            wp_reg    <= wp_next;
                            k_reg     <= '0;
                            t_reg     <= '0;
                            fin_reg   <= 1'b0;
                            state_reg <= ST_RUN;
                        end
                        else if (req.req_type == REQ_FINISH)
                        begin
                            k_reg     <= TAP_AW'(1);
                            t_reg     <= TAP_AW'(1);
                            fin_reg   <= 1'b1;
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (issue_ctl.last)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + TAP_AW'(1);
                    end
                end
                ST_WAIT:
                begin
                    if (mac_done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        res_reg.out_value    <= mac_acc;
                        res_reg.last_of_tail <= fin_reg && (t_reg == last_k);
                        res_valid_reg        <= 1'b1;
                        if (fin_reg && (t_reg != last_k))
                        begin
                            t_reg     <= t_reg + TAP_AW'(1);
                            k_reg     <= t_reg + TAP_AW'(1);
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_vld_reg  <= '0;
            hist_vld_reg <= '0;
            tap_ok_reg   <= 1'b0;
            hist_ok_reg  <= 1'b0;
            rd_ctl_reg   <= '0;
        end
        else
        begin
            if (accept && (req.req_type == REQ_TAP))
            begin
                tap_vld_reg[req.tap_index] <= 1'b1;
            end
            if (accept && (req.req_type == REQ_SAMPLE))
            begin
                hist_vld_reg[wp_next] <= 1'b1;
            end
            else if ((state_reg == ST_EMIT) && out_free && fin_reg && (t_reg == last_k))
            begin
                hist_vld_reg <= '0;
            end
            tap_ok_reg  <= tap_vld_reg[k_reg];
            hist_ok_reg <= hist_vld_reg[hist_addr];
            rd_ctl_reg  <= issue_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req.req_type == REQ_TAP))
        begin
            tap_mem[req.tap_index] <= req.value;
        end
        tap_q_reg <= tap_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req.req_type == REQ_SAMPLE))
        begin
            hist_mem[wp_next] <= req.value;
        end
        hist_q_reg <= hist_mem[hist_addr];
    end

    assign tap_op  = tap_ok_reg  ? tap_q_reg  : '0;
    assign hist_op = hist_ok_reg ? hist_q_reg : '0;

    sfc_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rd_ctl_reg),
        .op_a  (tap_op),
        .op_b  (hist_op),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[dv/streaming_fir_convolver_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the streaming FIR convolver: directed and random request streams.
module streaming_fir_convolver_tb;
    import sfc_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int HIST_DEPTH = MAX_TAPS - 1;
    localparam int SETTLE_CYCLES = 2 * MAX_TAPS + 20;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    in_item_t           req = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    out_item_t          res;
    logic               cfg_we = 1'b0;
    logic [LEN_W-1:0]   cfg_data = '0;

    logic signed [SMP_W-1:0] coef_mirror [MAX_TAPS];
    logic signed [SMP_W-1:0] hist_mirror [HIST_DEPTH];
    logic [LEN_W-1:0]        len_setting;
    out_item_t               pending_outputs [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int beats_sent = 0;
    int outputs_checked = 0;
    int length_writes = 0;
    int mismatches = 0;

    streaming_fir_convolver DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int taps_active();
        if (len_setting < LEN_MIN)
            return int'(LEN_MIN);
        if (len_setting > LEN_MAX)
            return MAX_TAPS;
        return int'(len_setting);
    endfunction

    function automatic logic [TAP_AW-1:0] rand_index();
        return TAP_AW'($urandom());
    endfunction

    function automatic logic [SMP_W-1:0] rand_value();
        return SMP_W'($urandom());
    endfunction

    function automatic in_item_t make_item(logic [1:0] kind, logic [TAP_AW-1:0] idx,
                                           logic [SMP_W-1:0] val);
        in_item_t it;
        it.req_type  = kind;
        it.tap_index = idx;
        it.value     = val;
        return it;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(9);
        if (r < 6)
            return LEN_W'($urandom_range(2, 12));
        if (r < 8)
            return LEN_W'($urandom_range(13, MAX_TAPS));
        return LEN_W'($urandom_range(0, 127));
    endfunction

    function automatic void predict_outputs(in_item_t it);
        int        len;
        longint    acc;
        out_item_t want;
        len = taps_active();
        case (it.req_type)
            REQ_TAP:
                coef_mirror[it.tap_index] = it.value;
            REQ_SAMPLE:
            begin
                acc = longint'(coef_mirror[0]) * longint'(it.value);
                for (int k = 1; k < len; k++)
                    acc += longint'(coef_mirror[k]) * longint'(hist_mirror[k - 1]);
                for (int k = HIST_DEPTH - 1; k > 0; k--)
                    hist_mirror[k] = hist_mirror[k - 1];
                hist_mirror[0] = it.value;
                want.out_value    = acc[ACC_W-1:0];
                want.last_of_tail = 1'b0;
                pending_outputs.push_back(want);
            end
            REQ_FINISH:
            begin
                for (int t = 1; t < len; t++)
                begin
                    acc = 0;
                    for (int k = t; k < len; k++)
                        acc += longint'(coef_mirror[k]) * longint'(hist_mirror[k - t]);
                    want.out_value    = acc[ACC_W-1:0];
                    want.last_of_tail = (t == len - 1);
                    pending_outputs.push_back(want);
                end
                for (int k = 0; k < HIST_DEPTH; k++)
                    hist_mirror[k] = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Receiver: checks each accepted result beat and decides the stall for the next cycle.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $error("unexpected result beat: out_value %0d, last_of_tail %0b",
                           res.out_value, res.last_of_tail);
                    mismatches++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    outputs_checked++;
                    if (res.out_value !== want.out_value)
                    begin
                        $error("out_value: expected %0d, actual %0d",
                               want.out_value, res.out_value);
                        mismatches++;
                    end
                    if (res.last_of_tail !== want.last_of_tail)
                    begin
                        $error("last_of_tail: expected %0b, actual %0b",
                               want.last_of_tail, res.last_of_tail);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                res_stall <= 1'b1;
            end
            else
                res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        predict_outputs(it);
        beats_sent++;
    endtask

    task automatic settle_idle();
        req_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] len);
        req_valid <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        cfg_we      <= 1'b0;
        len_setting  = len;
        length_writes++;
    endtask

    task automatic test_reset_state();
        send_item(make_item(REQ_FINISH, rand_index(), rand_value()));
        send_item(make_item(REQ_SAMPLE, rand_index(), 24'sh7FFFFF));
        settle_idle();
    endtask

    task automatic test_field_extremes();
        send_item(make_item(REQ_TAP, 6'd0, 24'sh800000));
        send_item(make_item(REQ_TAP, 6'd63, 24'sh800000));
        send_item(make_item(REQ_TAP, 6'd1, 24'sh7FFFFF));
        send_item(make_item(REQ_SAMPLE, 6'd63, 24'sh800000));
        send_item(make_item(REQ_SAMPLE, 6'd0, 24'sh7FFFFF));
        send_item(make_item(REQ_UNUSED, 6'd2, 24'sh7FFFFF));
        send_item(make_item(REQ_SAMPLE, 6'd0, 24'sh000000));
        send_item(make_item(REQ_FINISH, 6'd63, 24'shFFFFFF));
        settle_idle();
    endtask

    task automatic test_length_limits();
        logic [LEN_W-1:0] lengths [5];
        lengths = '{LEN_W'(0), LEN_W'(1), LEN_W'(2), LEN_W'(65), LEN_W'(127)};
        foreach (lengths[i])
        begin
            write_length(lengths[i]);
            send_item(make_item(REQ_SAMPLE, rand_index(), 24'sh800000));
            send_item(make_item(REQ_FINISH, rand_index(), rand_value()));
            settle_idle();
        end
        write_length(LEN_MAX);
    endtask

    task automatic test_midstream_length_change();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        for (int k = 0; k < 12; k++)
            send_item(make_item(REQ_TAP, TAP_AW'(k), rand_value()));
        write_length(LEN_W'(5));
        repeat (4) send_item(make_item(REQ_SAMPLE, rand_index(), rand_value()));
        settle_idle();
        write_length(LEN_W'(11));
        repeat (3) send_item(make_item(REQ_SAMPLE, rand_index(), rand_value()));
        settle_idle();
        write_length(LEN_W'(3));
        send_item(make_item(REQ_SAMPLE, rand_index(), rand_value()));
        send_item(make_item(REQ_FINISH, rand_index(), rand_value()));
        settle_idle();
    endtask

    task automatic test_output_backpressure();
        write_length(LEN_W'(8));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_left = 400;
        @(posedge clk);
        repeat (6) send_item(make_item(REQ_SAMPLE, rand_index(), rand_value()));
        send_item(make_item(REQ_FINISH, rand_index(), rand_value()));
        settle_idle();
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct, int target);
        int counted;
        int n;
        int r;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        counted = 0;
        while (counted < target)
        begin
            if ($urandom_range(7) == 0)
            begin
                settle_idle();
                write_length(pick_length());
            end
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                if ($urandom_range(4) != 0)
                    send_item(make_item(REQ_TAP,
                                        TAP_AW'($urandom_range(0, taps_active() - 1)),
                                        rand_value()));
                else
                    send_item(make_item(REQ_TAP, rand_index(), rand_value()));
                counted++;
            end
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                r = $urandom_range(19);
                if (r == 0)
                    send_item(make_item(REQ_UNUSED, rand_index(), rand_value()));
                else
                begin
                    send_item(make_item((r == 1) ? REQ_TAP : REQ_SAMPLE, rand_index(),
                                        rand_value()));
                    counted++;
                end
            end
            if ($urandom_range(9) != 0)
            begin
                send_item(make_item(REQ_FINISH, rand_index(), rand_value()));
                counted++;
            end
            if ($urandom_range(5) == 0)
            begin
                send_item(make_item(REQ_FINISH, rand_index(), rand_value()));
                counted++;
            end
        end
        settle_idle();
    endtask

    initial
    begin
        foreach (coef_mirror[i])
            coef_mirror[i] = '0;
        foreach (hist_mirror[i])
            hist_mirror[i] = '0;
        len_setting = LEN_MAX;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_field_extremes();
        test_length_limits();
        test_midstream_length_change();
        test_output_backpressure();
        run_random_phase(17, 74, 120);
        run_random_phase(74, 17, 120);
        run_random_phase(0, 0, 120);

        if (pending_outputs.size() != 0)
        begin
            $error("%0d expected result beats never arrived", pending_outputs.size());
            mismatches++;
        end
        $display("Sent %0d request beats and checked %0d result beats.",
                 beats_sent, outputs_checked);
        $display("Made %0d kernel length writes, out-of-range lengths included.",
                 length_writes);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #1_000_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
